/* hw/rtl/tbgd_pkg.sv */
package tbgd_pkg;

  // Width of the internal timestamp arithmetic; hold times wrap modulo 2**TimeBits.
  localparam int unsigned TimeBits = 32;
  // Width at which a hold time is compared with the 32-bit threshold.
  localparam int unsigned CmpBits = (TimeBits > 32) ? TimeBits : 32;
  localparam logic [31:0] LongPressReset = 32'd1000;

  typedef enum logic [2:0] {
    EvNone      = 3'd0,
    EvLeader    = 3'd1,
    EvLeftArm   = 3'd2,
    EvRightArm  = 3'd3,
    EvMode      = 3'd4,
    EvLeftTrig  = 3'd5,
    EvRightTrig = 3'd6
  } event_e;

  typedef struct packed {
    logic        left_pressed;
    logic        right_pressed;
    logic [31:0] time_ticks;
  } in_item_t;

  typedef struct packed {
    event_e      event_res;
    logic        leader_enabled;
    logic        mode_swerve;
    logic [31:0] request_number;
  } out_item_t;

  // True when the wrapped distance from start to now reaches the threshold.
  function automatic logic held_long(logic [TimeBits-1:0] now, logic [TimeBits-1:0] start,
                                     logic [31:0] limit);
    logic [TimeBits-1:0] diff;
    diff = now - start;
    return CmpBits'(diff) >= CmpBits'(limit);
  endfunction

endpackage

/* hw/rtl/two_button_gesture_decoder_core.sv */
// Channel  | Direction | Handshake                  | Item
// input    | in        | in_valid_i / in_ready_o    | in_item_i  (tbgd_pkg::in_item_t)
// result   | out       | out_valid_o / out_ready_i  | out_item_o (tbgd_pkg::out_item_t)
// config   | in        | cfg_we_i (no wait)         | cfg_wdata_i (long press threshold)
//
// Every item is held in the input register until the result register can take
// it; its result is visible once it enters the result register.
// A new item is taken every cycle while the result register is not stalled.
// Reset clears all gesture state, sets the threshold to 1000 ticks and empties
// both registers. A stalled result holds the input register, and only then does
// in_ready_o drop; the gesture state moves on when an item enters the result
// register.
module two_button_gesture_decoder_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tbgd_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tbgd_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i
);

  // Configuration register.
  logic [31:0] long_press_q;

  // Input register stage.
  logic               s1_valid_q;
  tbgd_pkg::in_item_t s1_item_q;

  // Result register stage.
  logic                out_valid_q;
  tbgd_pkg::out_item_t out_q;

  // Gesture state, advanced when an item moves from the input register into
  // the result register.
  logic prev_left_q, prev_right_q;
  logic both_seen_q, both_long_q, left_long_q, right_long_q;
  logic [tbgd_pkg::TimeBits-1:0] both_start_q, left_start_q, right_start_q;
  logic leader_q, mode_q;
  logic [31:0] req_q;

  logic prev_left_d, prev_right_d;
  logic both_seen_d, both_long_d, left_long_d, right_long_d;
  logic [tbgd_pkg::TimeBits-1:0] both_start_d, left_start_d, right_start_d;
  logic leader_d, mode_d;
  logic [31:0] req_d;
  tbgd_pkg::event_e ev_d;

  logic advance;

  // The input register empties whenever the result register can take its item.
  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Gesture decode for the item in the input register. The checks run in the
  // same order as the gesture rules, each seeing the updates of the earlier ones.
  always_comb begin
    logic                          l, r;
    logic [tbgd_pkg::TimeBits-1:0] now;
    logic [1:0]                    arm_incr;

    l   = s1_item_q.left_pressed;
    r   = s1_item_q.right_pressed;
    now = tbgd_pkg::TimeBits'(s1_item_q.time_ticks);
    arm_incr = 2'd0;

    prev_left_d   = l;
    prev_right_d  = r;
    both_seen_d   = both_seen_q;
    both_long_d   = both_long_q;
    left_long_d   = left_long_q;
    right_long_d  = right_long_q;
    both_start_d  = both_start_q;
    left_start_d  = left_start_q;
    right_start_d = right_start_q;
    leader_d      = leader_q;
    mode_d        = mode_q;
    ev_d          = tbgd_pkg::EvNone;

    // Both buttons held: first the start time is taken, then a long hold
    // toggles the leader flag once.
    if (l && r && !(left_long_q || right_long_q)) begin
      if (!both_seen_q || (!(prev_left_q && prev_right_q) && !both_long_q)) begin
        both_start_d = now;
      end else if (!both_long_q && tbgd_pkg::held_long(now, both_start_q, long_press_q)) begin
        both_long_d = 1'b1;
        leader_d    = !leader_q;
        ev_d        = tbgd_pkg::EvLeader;
      end
    end
    if (l && r) begin
      both_seen_d = 1'b1;
    end

    // A fresh press restarts that button's timer.
    if (l && !prev_left_q) begin
      left_start_d = now;
      left_long_d  = 1'b0;
    end
    if (r && !prev_right_q) begin
      right_start_d = now;
      right_long_d  = 1'b0;
    end

    // Single long holds; they raise an arm toggle only while the leader flag
    // is set, but always suppress the trigger on release.
    if (l && !both_seen_d && !left_long_d &&
        tbgd_pkg::held_long(now, left_start_d, long_press_q)) begin
      if (leader_d) begin
        arm_incr = arm_incr + 2'd1;
        ev_d     = tbgd_pkg::EvLeftArm;
      end
      left_long_d = 1'b1;
    end
    if (r && !both_seen_d && !right_long_d &&
        tbgd_pkg::held_long(now, right_start_d, long_press_q)) begin
      if (leader_d) begin
        arm_incr = arm_incr + 2'd1;
        ev_d     = tbgd_pkg::EvRightArm;
      end
      right_long_d = 1'b1;
    end
    req_d = req_q + 32'(arm_incr);

    // Full release: short presses are judged here and the hold flags cleared.
    if (!l && !r && (prev_left_q || prev_right_q)) begin
      if (both_seen_d) begin
        if (!both_long_d && !left_long_d && !right_long_d) begin
          mode_d = !mode_q;
          ev_d   = tbgd_pkg::EvMode;
        end
      end else if (!prev_left_q && prev_right_q && !right_long_d) begin
        ev_d = tbgd_pkg::EvRightTrig;
      end else if (prev_left_q && !prev_right_q && !left_long_d) begin
        ev_d = tbgd_pkg::EvLeftTrig;
      end
      both_seen_d  = 1'b0;
      both_long_d  = 1'b0;
      left_long_d  = 1'b0;
      right_long_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q  <= tbgd_pkg::LongPressReset;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      prev_left_q   <= 1'b0;
      prev_right_q  <= 1'b0;
      both_seen_q   <= 1'b0;
      both_long_q   <= 1'b0;
      left_long_q   <= 1'b0;
      right_long_q  <= 1'b0;
      both_start_q  <= '0;
      left_start_q  <= '0;
      right_start_q <= '0;
      leader_q      <= 1'b0;
      mode_q        <= 1'b0;
      req_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        long_press_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        prev_left_q   <= prev_left_d;
        prev_right_q  <= prev_right_d;
        both_seen_q   <= both_seen_d;
        both_long_q   <= both_long_d;
        left_long_q   <= left_long_d;
        right_long_q  <= right_long_d;
        both_start_q  <= both_start_d;
        left_start_q  <= left_start_d;
        right_start_q <= right_start_d;
        leader_q      <= leader_d;
        mode_q        <= mode_d;
        req_q         <= req_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_q.event_res      <= ev_d;
      out_q.leader_enabled <= leader_d;
      out_q.mode_swerve    <= mode_d;
      out_q.request_number <= req_d;
    end
  end

  // A full input register behind a stalled result must not take another item.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are stalled");

  // The shown result always matches the gesture state it was built with.
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.leader_enabled == leader_q) && (out_q.mode_swerve == mode_q) &&
                    (out_q.request_number == req_q))
    else $error("result register and gesture state disagree");

  // An arm toggle is only ever raised with the leader flag set.
  a_arm_needs_leader: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.event_res == tbgd_pkg::EvLeftArm ||
                    out_q.event_res == tbgd_pkg::EvRightArm) |-> out_q.leader_enabled)
    else $error("arm toggle without leader flag");

  // A leader toggle marks the two-button hold as consumed.
  a_leader_marks_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.event_res == tbgd_pkg::EvLeader |-> both_long_q && both_seen_q)
    else $error("leader toggle left the hold unmarked");

endmodule

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is stopped here whatever happens.
  localparam int unsigned CycleLimit = 200000;
  // Each phase of random gestures is at least this many items, split into chunks that
  // each run under one threshold.
  localparam int unsigned PhaseItems = 300;
  localparam int unsigned ChunkItems = 100;
  // A short pause after the last result is enough for the block to be idle.
  localparam int unsigned SettleCycles = 5;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  tbgd_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  tbgd_pkg::out_item_t out_item_o;
  logic                cfg_we_i    = 1'b0;
  logic [31:0]         cfg_wdata_i = '0;

  // Percentage of cycles in which the sender holds back and the receiver
  // stalls. They are changed between the phases of the run.
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 56;

  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count  = 0;
  int unsigned event_seen[8];
  int unsigned threshold_writes = 0;

  // Results that the gesture model has worked out and that the block has not
  // yet delivered, oldest first.
  tbgd_pkg::out_item_t pending_results[$];

  // The gesture model's own copy of the block's state.
  logic [31:0] thr_ticks;
  logic        prev_l, prev_r;
  logic        both_seen, both_long, l_long, r_long;
  logic [31:0] both_start, l_start, r_start;
  logic        leader_on, mode_swerve;
  logic [31:0] req_count;

  // Running timestamp used to build the random gestures.
  logic [31:0] tick_now = '0;

  two_button_gesture_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The hold time is the wrapped distance between two timestamps, compared
  // as an unsigned number against the threshold.
  function automatic logic long_enough(logic [31:0] now, logic [31:0] start);
    logic [31:0] span;
    span = now - start;
    return span >= thr_ticks;
  endfunction

  function automatic void clear_gestures();
    thr_ticks   = tbgd_pkg::LongPressReset;
    prev_l      = 1'b0;
    prev_r      = 1'b0;
    both_seen   = 1'b0;
    both_long   = 1'b0;
    l_long      = 1'b0;
    r_long      = 1'b0;
    both_start  = '0;
    l_start     = '0;
    r_start     = '0;
    leader_on   = 1'b0;
    mode_swerve = 1'b0;
    req_count   = '0;
  endfunction

  // Works out the gesture event for one accepted sample, moves the model's
  // state on and queues the result that the block must deliver.
  function automatic void decode_gesture(tbgd_pkg::in_item_t smp);
    logic                l, r;
    logic [1:0]          cur, prv;
    logic [31:0]         now;
    tbgd_pkg::event_e    ev;
    tbgd_pkg::out_item_t res;
    l   = smp.left_pressed;
    r   = smp.right_pressed;
    now = smp.time_ticks;
    cur = {l, r};
    prv = {prev_l, prev_r};
    ev  = tbgd_pkg::EvNone;

    // Both held: the first sample of a chord only records its start, and the
    // leader flag flips once the chord has been held long enough. A chord
    // that follows a completed single long press is ignored.
    if (cur == 2'b11 && !(l_long || r_long)) begin
      if (!both_seen || (prv != 2'b11 && !both_long)) begin
        both_start = now;
      end else if (!both_long && long_enough(now, both_start)) begin
        both_long = 1'b1;
        leader_on = ~leader_on;
        ev        = tbgd_pkg::EvLeader;
      end
    end
    if (cur == 2'b11) begin
      both_seen = 1'b1;
    end

    if (l && !prev_l) begin
      l_start = now;
      l_long  = 1'b0;
    end
    if (r && !prev_r) begin
      r_start = now;
      r_long  = 1'b0;
    end

    // A single long hold always counts as done, but only raises an arm
    // toggle while the leader flag is set.
    if (l && !both_seen && !l_long && long_enough(now, l_start)) begin
      if (leader_on) begin
        req_count = req_count + 32'd1;
        ev        = tbgd_pkg::EvLeftArm;
      end
      l_long = 1'b1;
    end
    if (r && !both_seen && !r_long && long_enough(now, r_start)) begin
      if (leader_on) begin
        req_count = req_count + 32'd1;
        ev        = tbgd_pkg::EvRightArm;
      end
      r_long = 1'b1;
    end

    // Full release judges the short presses.
    if (cur == 2'b00 && prv != 2'b00) begin
      if (both_seen) begin
        if (!both_long && !l_long && !r_long) begin
          mode_swerve = ~mode_swerve;
          ev          = tbgd_pkg::EvMode;
        end
      end else if (prv == 2'b01 && !r_long) begin
        ev = tbgd_pkg::EvRightTrig;
      end else if (prv == 2'b10 && !l_long) begin
        ev = tbgd_pkg::EvLeftTrig;
      end
      both_seen = 1'b0;
      both_long = 1'b0;
      l_long    = 1'b0;
      r_long    = 1'b0;
    end

    prev_l = l;
    prev_r = r;

    res.event_res      = ev;
    res.leader_enabled = leader_on;
    res.mode_swerve    = mode_swerve;
    res.request_number = req_count;
    pending_results.push_back(res);
  endfunction

  // Offers one sample and waits until the block takes it. Valid is left high
  // afterwards; the next call either replaces the item or lowers valid for a
  // gap, so that it is never lowered and raised in the same step.
  task automatic send_sample(input logic l, input logic r, input logic [31:0] ticks);
    tbgd_pkg::in_item_t smp;
    smp.left_pressed  = l;
    smp.right_pressed = r;
    smp.time_ticks    = ticks;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= smp;
    do begin
      @(posedge clk_i);
    end while (!(in_valid_i && in_ready_o));
    decode_gesture(smp);
    accepted_count++;
  endtask

  // Stops sending and waits until every queued result has arrived, then
  // lets the pipeline settle.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The threshold is only changed while the block is idle.
  task automatic write_threshold(input logic [31:0] value);
    wait_results_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    thr_ticks  = value;
    threshold_writes++;
  endtask

  // Next timestamp for a random gesture. Most steps stay around the
  // threshold so that short and long holds both happen; some land exactly on
  // it or just short of it, some go backwards, and some jump anywhere.
  task automatic advance_ticks();
    logic [31:0] span;
    span = (thr_ticks > 32'd5000) ? 32'd5000 : thr_ticks + 32'd3;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: tick_now = tick_now + $urandom_range(span);
      5:             tick_now = tick_now + thr_ticks;
      6:             tick_now = tick_now + thr_ticks - 32'd1;
      7:             tick_now = tick_now - $urandom_range(40, 1);
      8:             tick_now = $urandom;
      default:       tick_now = tick_now + $urandom_range(span / 4);
    endcase
  endtask

  task automatic gesture_sample(input logic l, input logic r);
    advance_ticks();
    send_sample(l, r, tick_now);
  endtask

  // One random gesture. Most are well formed (press, hold, full release) so
  // that the long-hold and release paths are reached; the rest overlap the
  // buttons, leave them pressed, or are plain noise.
  task automatic random_gesture();
    logic side;
    int   hold;
    side = 1'($urandom_range(1));
    hold = $urandom_range(4, 1);
    case ($urandom_range(9))
      0, 1, 2: begin
        repeat (hold) gesture_sample(side, ~side);
        gesture_sample(1'b0, 1'b0);
      end
      3, 4, 5: begin
        repeat ($urandom_range(2)) gesture_sample(side, ~side);
        repeat (hold) gesture_sample(1'b1, 1'b1);
        repeat ($urandom_range(2)) gesture_sample(~side, side);
        gesture_sample(1'b0, 1'b0);
      end
      6: begin
        // A single hold that grows into a chord and then lets go of the
        // first button.
        repeat (hold) gesture_sample(side, ~side);
        repeat ($urandom_range(3, 1)) gesture_sample(1'b1, 1'b1);
        repeat ($urandom_range(2)) gesture_sample(~side, side);
        gesture_sample(1'b0, 1'b0);
      end
      7: begin
        // Two separate singles with a release between them.
        gesture_sample(side, ~side);
        gesture_sample(1'b0, 1'b0);
        repeat (hold) gesture_sample(~side, side);
        gesture_sample(1'b0, 1'b0);
      end
      default: begin
        repeat (hold) gesture_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    endcase
  endtask

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(20, 1);
      3:       return $urandom_range(3000, 20);
      4:       return $urandom;
      default: return tbgd_pkg::LongPressReset;
    endcase
  endfunction

  // With the leader flag clear, a long single hold raises nothing and still
  // swallows the trigger on release. The reset threshold is used here.
  task automatic test_leader_off_hold();
    send_sample(1'b1, 1'b0, 32'd0);
    send_sample(1'b1, 1'b0, 32'd1500);
    send_sample(1'b0, 1'b0, 32'd1510);
  endtask

  task automatic test_short_triggers();
    write_threshold(32'd100);
    send_sample(1'b0, 1'b1, 32'd200);
    send_sample(1'b0, 1'b0, 32'd210);
    send_sample(1'b1, 1'b0, 32'd300);
    send_sample(1'b0, 1'b0, 32'd305);
  endtask

  task automatic test_chords();
    // A short chord swaps the mode on release.
    send_sample(1'b1, 1'b1, 32'd400);
    send_sample(1'b1, 1'b1, 32'd450);
    send_sample(1'b0, 1'b0, 32'd460);
    // A long chord turns the leader flag on, and its release is silent.
    send_sample(1'b1, 1'b1, 32'd500);
    send_sample(1'b1, 1'b1, 32'd600);
    send_sample(1'b0, 1'b0, 32'd610);
  endtask

  task automatic test_arm_toggles();
    send_sample(1'b1, 1'b0, 32'd700);
    send_sample(1'b1, 1'b0, 32'd800);
    send_sample(1'b0, 1'b0, 32'd801);
    // Time running backwards looks like a very long hold.
    send_sample(1'b0, 1'b1, 32'd900);
    send_sample(1'b0, 1'b1, 32'd850);
    send_sample(1'b0, 1'b0, 32'd860);
  endtask

  // A hold across the timestamp wrap is measured modulo 2**32 and stays short.
  task automatic test_time_wrap();
    send_sample(1'b1, 1'b0, 32'hFFFF_FFF0);
    send_sample(1'b1, 1'b0, 32'h0000_0050);
    send_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
  endtask

  task automatic test_threshold_extremes();
    // With a zero threshold the chord's first sample still only records the
    // start; the second one at the same time completes the long hold.
    write_threshold(32'd0);
    send_sample(1'b1, 1'b1, 32'd5);
    send_sample(1'b1, 1'b1, 32'd5);
    send_sample(1'b0, 1'b0, 32'd5);
    // At the largest threshold only a step of one tick backwards is long.
    write_threshold(32'hFFFF_FFFF);
    send_sample(1'b1, 1'b0, 32'd20);
    send_sample(1'b1, 1'b0, 32'd19);
    send_sample(1'b0, 1'b0, 32'd30);
  endtask

  // One phase of random gestures under a given idling pattern. Between the
  // chunks the sender pauses until every result is in, and a new threshold
  // is written.
  task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned phase_end;
    int unsigned chunk_end;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    phase_end     = accepted_count + PhaseItems;
    while (accepted_count < phase_end) begin
      write_threshold(pick_threshold());
      chunk_end = accepted_count + ChunkItems;
      while (accepted_count < chunk_end) begin
        random_gesture();
      end
    end
  endtask

  // Results are checked as they are taken; the ready line is redrawn every
  // cycle from the receiver's idling rate.
  always @(posedge clk_i) begin
    tbgd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected: actual %p", $time, out_item_o);
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        event_seen[out_item_o.event_res]++;
        if (out_item_o.event_res !== want.event_res) begin
          error_count++;
          $display("%0t: event_res expected %0d actual %0d", $time,
                   want.event_res, out_item_o.event_res);
        end
        if (out_item_o.leader_enabled !== want.leader_enabled) begin
          error_count++;
          $display("%0t: leader_enabled expected %0d actual %0d", $time,
                   want.leader_enabled, out_item_o.leader_enabled);
        end
        if (out_item_o.mode_swerve !== want.mode_swerve) begin
          error_count++;
          $display("%0t: mode_swerve expected %0d actual %0d", $time,
                   want.mode_swerve, out_item_o.mode_swerve);
        end
        if (out_item_o.request_number !== want.request_number) begin
          error_count++;
          $display("%0t: request_number expected %0d actual %0d", $time,
                   want.request_number, out_item_o.request_number);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: run stopped after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clear_gestures();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed gestures first, under the first idling pattern.
    test_leader_off_hold();
    test_short_triggers();
    test_chords();
    test_arm_toggles();
    test_time_wrap();
    test_threshold_extremes();

    // Random gestures: sender idling less than receiver, then the reverse, then
    // both running flat out.
    test_random_phase(34, 56);
    test_random_phase(56, 34);
    test_random_phase(0, 0);

    wait_results_drained();

    $display("Covered %0d samples and %0d results over %0d threshold settings.",
             accepted_count, checked_count, threshold_writes);
    $display("Events: none %0d, leader %0d, arm L/R %0d/%0d, mode %0d, trigger L/R %0d/%0d.",
             event_seen[tbgd_pkg::EvNone], event_seen[tbgd_pkg::EvLeader],
             event_seen[tbgd_pkg::EvLeftArm], event_seen[tbgd_pkg::EvRightArm],
             event_seen[tbgd_pkg::EvMode], event_seen[tbgd_pkg::EvLeftTrig],
             event_seen[tbgd_pkg::EvRightTrig]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
